// ===== hdl/ors_pkg.sv =====
// Shared definitions for the overwriting ring stack: operation and status
// codes, the register map and the result flag bundle.
// No dependencies.
`default_nettype none

package ors_pkg;

    // Operation codes carried in the input tuser.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Status codes reported with every result.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_UNDERFLOW = 1'b1;

    // Register map: register index, taken from the word address.
    localparam logic REG_CAPACITY = 1'b0;

    // Capacity register and count width, and the capacity after reset.
    localparam int unsigned CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Element port width of the stream channels.
    localparam int unsigned DATA_BITS = 32;

    // Flags that travel with a result next to the element value.
    typedef struct packed {
        logic                value_valid;
        logic                status;
        logic [CAP_BITS-1:0] count;
        logic                is_empty;
        logic                is_full;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/overwriting_ring_stack.sv =====
// Overwriting ring stack top level: stream channels, APB register port,
// the slot memory and the pointer and count logic. Depends on ors_pkg.
//
// Usage: push and pop requests arrive on the s_ channel; s_tuser[0] selects
// push (0) or pop (1) and s_tdata carries the element to push. Every request
// gives exactly one result on the m_ channel, in the cycle after its transfer.
// The result is the popped element, or the element evicted by a push onto a
// full stack, with the count and the empty and full flags after the
// operation; a pop on an empty stack reports underflow and changes nothing.
// Throughput is one request per cycle while s_tready is high. A push or a
// non-empty pop does one read-first memory access and updates pointer and
// count at the transfer; a push reads and replaces the entry at one address.
// The memory read data register is the output register, so s_tready drops
// while a result waits and the receiver holds m_tready low; a stalled result
// keeps its values. Reset empties the stack and sets the capacity to 16; the
// slot contents are not cleared and need no sweep. Writing the capacity
// register empties the stack too and may only happen while the block idles.
`default_nettype none

module overwriting_ring_stack
    import ors_pkg::*;
#(
    parameter int unsigned DEPTH        = 16,
    parameter int unsigned ELEMENT_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Request channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // [31:0] push_value
    input  wire logic [0:0]            s_tuser,   // [0] kind
    // Result channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [39:0]                m_tdata,   // [31:0] out_value, [36:32] count,
                                                  // [37] is_empty, [38] is_full, zeros
    output logic [1:0]                 m_tuser,   // [0] value_valid, [1] status
    // Register port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW      = ((AW > CAP_BITS) ? AW : CAP_BITS) + 1;
    localparam int unsigned CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

    // Configuration and stack state.
    logic [CAP_BITS-1:0]     r_capacity;
    logic [AW-1:0]           r_top, n_top;
    logic [CAP_BITS-1:0]     r_count, n_count;

    // Slot memory and its registered read data.
    logic [ELEMENT_BITS-1:0] r_mem [DEPTH];
    logic [ELEMENT_BITS-1:0] r_rd_data;

    // Output register.
    logic                    r_out_valid;
    t_result                 r_res, n_res;

    logic                    in_xfer;
    logic                    cfg_wr;
    logic [CAP_BITS-1:0]     cap_eff;
    logic [XW-1:0]           cap_x;
    logic [XW-1:0]           top_x;
    logic [XW-1:0]           top_adj;
    logic [XW-1:0]           top_inc;
    logic [AW-1:0]           mem_addr;
    logic                    mem_en;
    logic                    mem_we;
    logic [63:0]             push_wide;
    logic [ELEMENT_BITS-1:0] push_elem;
    logic [63:0]             rd_wide;

    // Register port: always ready, one register at word index zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? {27'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[CAP_BITS-1:0];
        end
    end

    // Capacity in force: zero acts as one, values above the depth clamp.
    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = CAP_BITS'(1);
        end else if (32'(r_capacity) > CAP_MAX) begin
            cap_eff = CAP_BITS'(CAP_MAX);
        end else begin
            cap_eff = r_capacity;
        end
    end

    assign cap_x   = XW'(cap_eff);
    assign top_x   = XW'(r_top);
    assign top_adj = (top_x >= cap_x) ? '0 : top_x;
    assign top_inc = top_adj + XW'(1);

    // A request transfers only while the output register is free or draining.
    assign s_tready = !r_out_valid || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    // Element to store, kept to the element width.
    assign push_wide = {32'd0, s_tdata};
    assign push_elem = push_wide[ELEMENT_BITS-1:0];

    // Next pointer, count, memory access and result flags for one request.
    always_comb begin
        n_top    = r_top;
        n_count  = r_count;
        mem_addr = top_adj[AW-1:0];
        mem_en   = 1'b0;
        mem_we   = 1'b0;
        n_res    = '0;
        if (in_xfer) begin
            if (s_tuser[0] == KIND_PUSH) begin
                mem_en = 1'b1;
                mem_we = 1'b1;
                n_res.value_valid = (r_count >= cap_eff);
                n_res.status      = STATUS_OK;
                n_top   = (top_inc >= cap_x) ? '0 : top_inc[AW-1:0];
                n_count = (r_count >= cap_eff) ? cap_eff : r_count + CAP_BITS'(1);
            end else if (r_count == '0) begin
                // Pop on an empty stack: rejected, state kept.
                n_res.status = STATUS_UNDERFLOW;
            end else begin
                mem_en   = 1'b1;
                mem_addr = (top_adj == '0) ? AW'(cap_x - XW'(1))
                                           : AW'(top_adj - XW'(1));
                n_top    = mem_addr;
                n_count  = r_count - CAP_BITS'(1);
                n_res.value_valid = 1'b1;
                n_res.status      = STATUS_OK;
            end
            n_res.count    = n_count;
            n_res.is_empty = (n_count == '0);
            n_res.is_full  = (n_count == cap_eff);
        end
    end

    // Pointer and count; a capacity write empties the stack.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_count <= '0;
        end else if (cfg_wr) begin
            r_top   <= '0;
            r_count <= '0;
        end else begin
            r_top   <= n_top;
            r_count <= n_count;
        end
    end

    // Read-first slot memory: an eviction reads the old entry as it is replaced.
    always_ff @(posedge i_clk) begin
        if (mem_en) begin
            if (mem_we) begin
                r_mem[mem_addr] <= push_elem;
            end
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= n_res;
        end
    end

    assign rd_wide  = 64'(r_rd_data);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_res.is_full, r_res.is_empty, r_res.count,
                       r_res.value_valid ? rd_wide[DATA_BITS-1:0] : 32'd0};
    assign m_tuser  = {r_res.status, r_res.value_valid};

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the overwriting ring stack: stream requests and
// results, capacity writes over the APB port, and a scoreboard that tracks the stack.
// Depends on ors_pkg and overwriting_ring_stack.
`timescale 1ns / 1ps

module tb_top;
    import ors_pkg::*;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned RESULT_BITS = 40;
    localparam int unsigned PHASE_ITEMS = 80;
    localparam int unsigned PHASES      = 10;
    localparam int unsigned PRINT_LIMIT = 100;

    // Tracks the stack contents, pointer, count and capacity, and holds the
    // results that are still to arrive from the block.
    class ring_stack_scoreboard;
        typedef struct {
            logic [DATA_BITS-1:0] value;
            t_result              flags;
        } t_outcome;

        logic [DATA_BITS-1:0] slots [STACK_DEPTH];
        int unsigned          top_slot;
        int unsigned          held;
        logic [CAP_BITS-1:0]  cap_setting;
        t_outcome             awaited[$];
        int unsigned          mismatch_count;

        function new();
            top_slot       = 0;
            held           = 0;
            cap_setting    = CAP_RESET;
            mismatch_count = 0;
        endfunction

        // A register value of zero acts as one slot, values above the depth as the depth.
        function int unsigned usable_slots();
            int unsigned cap;
            cap = cap_setting;
            if (cap == 0)
                cap = 1;
            if (cap > STACK_DEPTH)
                cap = STACK_DEPTH;
            return cap;
        endfunction

        // A capacity write empties the stack but keeps the slot contents.
        function void set_capacity(logic [CAP_BITS-1:0] value);
            cap_setting = value;
            top_slot    = 0;
            held        = 0;
        endfunction

        // Applies one accepted request and queues the result it must give.
        function void note_request(logic kind, logic [DATA_BITS-1:0] value);
            int unsigned cap;
            int unsigned slot;
            logic        overflow;
            t_outcome    res;
            cap = usable_slots();
            slot = (top_slot >= cap) ? 0 : top_slot;
            res.value = '0;
            res.flags = '0;
            res.flags.status = STATUS_OK;
            if (kind == KIND_PUSH) begin
                // A push onto a full stack evicts the oldest entry at the top slot.
                overflow = (held >= cap);
                if (overflow) begin
                    res.value = slots[slot];
                    res.flags.value_valid = 1'b1;
                end
                slots[slot] = value;
                slot = (slot + 1 >= cap) ? 0 : slot + 1;
                top_slot = slot;
                held = overflow ? cap : held + 1;
            end else if (held == 0) begin
                res.flags.status = STATUS_UNDERFLOW;
            end else begin
                slot = (slot == 0) ? cap - 1 : slot - 1;
                top_slot = slot;
                res.value = slots[slot];
                res.flags.value_valid = 1'b1;
                held = held - 1;
            end
            res.flags.count    = CAP_BITS'(held);
            res.flags.is_empty = (held == 0);
            res.flags.is_full  = (held == cap);
            awaited.push_back(res);
        endfunction

        task report_mismatch(input string msg);
            mismatch_count++;
            if (mismatch_count <= PRINT_LIMIT)
                $display("ERROR at %0t ns: %s", $time, msg);
        endtask

        // Compares one result transfer with the oldest queued result, field by field.
        task check_result(input logic [RESULT_BITS-1:0] data, input logic [1:0] user);
            t_outcome want;
            string    diffs;
            if (awaited.size() == 0) begin
                report_mismatch("result transfer with no request outstanding");
                return;
            end
            want = awaited.pop_front();
            diffs = "";
            if (data[31:0] !== want.value)
                diffs = {diffs, $sformatf(" out_value %h/%h", data[31:0], want.value)};
            if (user[0] !== want.flags.value_valid)
                diffs = {diffs, $sformatf(" value_valid %b/%b", user[0],
                                          want.flags.value_valid)};
            if (user[1] !== want.flags.status)
                diffs = {diffs, $sformatf(" status %b/%b", user[1], want.flags.status)};
            if (data[36:32] !== want.flags.count)
                diffs = {diffs, $sformatf(" count %0d/%0d", data[36:32], want.flags.count)};
            if (data[37] !== want.flags.is_empty)
                diffs = {diffs, $sformatf(" is_empty %b/%b", data[37], want.flags.is_empty)};
            if (data[38] !== want.flags.is_full)
                diffs = {diffs, $sformatf(" is_full %b/%b", data[38], want.flags.is_full)};
            if (data[39] !== 1'b0)
                diffs = {diffs, $sformatf(" padding %b/0", data[39])};
            if (diffs != "")
                report_mismatch({"result fields differ (got/want):", diffs});
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [31:0]            s_tdata;    // [31:0] push_value
    logic [0:0]             s_tuser;    // [0] kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RESULT_BITS-1:0] m_tdata;    // [31:0] out_value, [36:32] count, [37] is_empty,
                                        // [38] is_full, zeros
    logic [1:0]             m_tuser;    // [0] value_valid, [1] status
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   quiet = 1'b0;

    ring_stack_scoreboard tracker = new();

    overwriting_ring_stack #(
        .DEPTH        (STACK_DEPTH),
        .ELEMENT_BITS (DATA_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    // The receiver drops m_tready at random, with a chance of about 13 percent, except during a quiet phase.
    always @(posedge i_clk) begin
        m_tready <= quiet || ($urandom_range(99) >= 13);
    end

    // Both channels are sampled at the edge, before any new drive takes effect.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                tracker.note_request(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata, m_tuser);
        end
    end

    // Capacity settings of the random phases, the extremes among them.
    function logic [CAP_BITS-1:0] phase_capacity(input int unsigned phase);
        case (phase)
            0: return 5'd31;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd0;
            4: return 5'd2;
            5: return 5'd7;
            6: return 5'd17;
            7: return 5'd4;
            8: return 5'd16;
            default: return 5'd3;
        endcase
    endfunction

    // Offers one request, after an occasional idle gap, and waits for its transfer.
    task send_request(input logic kind, input logic [31:0] value);
        if (!quiet && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= kind;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stops offering requests and waits until every queued result has arrived.
    task settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // APB write of the capacity register: setup cycle, then access cycle.
    task write_capacity(input logic [CAP_BITS-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_capacity(value);
    endtask

    initial begin
        int unsigned left;
        int unsigned bias;
        int unsigned burst;
        logic        kind;
        logic [31:0] value;

        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_PUSH;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset capacity: underflow on an empty stack, extreme values, pops to empty.
        send_request(KIND_POP, 32'hDEAD_BEEF);
        send_request(KIND_PUSH, 32'h0000_0000);
        send_request(KIND_PUSH, 32'hFFFF_FFFF);
        send_request(KIND_POP, 32'h1234_5678);
        send_request(KIND_POP, 32'h0000_0000);
        send_request(KIND_POP, 32'hFFFF_FFFF);
        settle();

        // Two slots: pushes onto a full stack evict the oldest entries, pointer wraps.
        write_capacity(5'd2);
        send_request(KIND_PUSH, 32'hA5A5_5A5A);
        send_request(KIND_PUSH, 32'h5A5A_A5A5);
        send_request(KIND_PUSH, 32'h0F0F_F0F0);
        send_request(KIND_PUSH, 32'hF0F0_0F0F);
        send_request(KIND_POP, 32'h0);
        send_request(KIND_POP, 32'h0);
        send_request(KIND_POP, 32'h0);
        send_request(KIND_PUSH, 32'h8000_0001);
        settle();

        // A capacity write empties a non-empty stack; zero acts as one slot.
        write_capacity(5'd0);
        send_request(KIND_POP, 32'h0);
        send_request(KIND_PUSH, 32'h1111_1111);
        send_request(KIND_PUSH, 32'h2222_2222);
        send_request(KIND_POP, 32'h0);
        settle();

        // Values above the depth act as the full depth.
        write_capacity(5'd31);
        send_request(KIND_PUSH, 32'h7FFF_FFFE);
        send_request(KIND_POP, 32'h0);
        settle();

        // Random phases: bursts that lean toward pushes or pops reach full and empty.
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            write_capacity(phase_capacity(phase));
            quiet = (phase == 2);
            left = PHASE_ITEMS;
            while (left > 0) begin
                case ($urandom_range(2))
                    0: bias = 15;
                    1: bias = 50;
                    default: bias = 85;
                endcase
                burst = $urandom_range(8, 24);
                for (int unsigned k = 0; k < burst && left > 0; k++) begin
                    kind = ($urandom_range(99) < bias) ? KIND_PUSH : KIND_POP;
                    value = $urandom;
                    if ($urandom_range(9) == 0)
                        value = $urandom_range(1) ? '1 : '0;
                    send_request(kind, value);
                    left--;
                end
            end
            settle();
            quiet = 1'b0;
        end

        repeat (4) @(posedge i_clk);
        if (tracker.mismatch_count == 0) begin
            $display("overwriting_ring_stack: match");
        end else begin
            $display("overwriting_ring_stack: mismatch");
        end
        $finish;
    end

    // Ends a run that hangs, for instance on a result that never arrives.
    initial begin
        #2_000_000;
        $display("overwriting_ring_stack: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ors_pkg.sv
hdl/overwriting_ring_stack.sv
verif/tb_top.sv
